// File: rtl/core/lrubc_pkg.sv
// ----------------------------------------------------------------------------
// LRU buffer cache package
// Shared widths, request and status codes and sequencer states of the
// buffer cache tag and replacement engine.
// ----------------------------------------------------------------------------
package lrubc_pkg;

  localparam int FUNC_W   = 2;
  localparam int DEV_W    = 8;
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 8;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam func_t FUNC_GET     = 2'd0;
  localparam func_t FUNC_RELEASE = 2'd1;
  localparam func_t FUNC_PIN     = 2'd2;
  localparam func_t FUNC_UNPIN   = 2'd3;

  localparam status_t STATUS_OK     = 3'd0;
  localparam status_t STATUS_MISS   = 3'd1;
  localparam status_t STATUS_NOFREE = 3'd2;
  localparam status_t STATUS_UNDER  = 3'd3;
  localparam status_t STATUS_OVER   = 3'd4;

  localparam cnt_t CNT_MAX = 8'd255;
  localparam cnt_t CNT_ONE = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SLOT_RD,
    ST_SLOT_UPD,
    ST_SWEEP,
    ST_FINAL
  } state_t;

endpackage

// File: rtl/core/lru_block_buffer_cache_unit.sv
// A get scans the entries up to a hit or the last one; release, pin and unpin
// read and update the named slot, and a release that drops a count to zero
// also sweeps the ranks in the rank memory to keep the recency order.
// One item at a time: busy stays high until the result is shown; the next
// item may start in the cycle of the strobe. The receiver cannot stall.
// Reset is synchronous: all entries unused, counts zero, ranks by index.
// ----------------------------------------------------------------------------
// LRU buffer cache tag and replacement engine
// Scans tag and count memories one entry per cycle under a small sequencer
// to find hits, claim the least recently released free entry and keep the
// release recency order.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lrubc_pkg::func_t          in_func,
  input  logic [lrubc_pkg::DEV_W-1:0]    in_dev,
  input  logic [lrubc_pkg::SECTOR_W-1:0] in_sector,
  input  logic [lrubc_pkg::SLOT_W-1:0]   in_slot,
  output logic                      out_valid,
  output logic [lrubc_pkg::SLOT_W-1:0]   out_entry,
  output lrubc_pkg::status_t        out_status,
  output lrubc_pkg::cnt_t           out_count_after
);
  import lrubc_pkg::*;

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam int MW = CNT_W + IW;
  localparam int TW = DEV_W + SECTOR_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);
  localparam logic [CW-1:0] N_CNT    = CW'(NUM_BUFFERS);

  logic [TW-1:0] tag_mem  [NUM_BUFFERS];
  logic [MW-1:0] meta_mem [NUM_BUFFERS];

  state_t state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [TW-1:0] tag_rd_r;
  logic [MW-1:0] meta_rd_r;
  logic [NUM_BUFFERS-1:0] used_r;
  logic [NUM_BUFFERS-1:0] mv_r;

  func_t                func_r;
  logic [DEV_W-1:0]     dev_r;
  logic [SECTOR_W-1:0]  sector_r;
  logic [SLOT_W-1:0]    slot_r;

  logic          cand_found_r, cand_found_nxt;
  logic [IW-1:0] cand_idx_r, cand_idx_nxt;
  logic [IW-1:0] cand_rank_r, cand_rank_nxt;
  logic [IW-1:0] sweep_rank_r, sweep_rank_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   out_entry_r, out_entry_nxt;
  status_t             out_status_r, out_status_nxt;
  cnt_t                out_count_r, out_count_nxt;

  logic          accept;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          tag_we;
  logic          meta_we;
  logic          set_used;
  logic [MW-1:0] meta_wdata;
  logic [IW-1:0] slot_idx;
  cnt_t          eff_cnt;
  logic [IW-1:0] eff_rank;
  cnt_t          cnt_p1;
  cnt_t          cnt_m1;
  logic          hit;
  logic          take;
  logic          c_found;
  logic [IW-1:0] c_idx;
  logic [IW-1:0] c_rank;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign slot_idx = IW'(slot_r);

  assign eff_cnt  = mv_r[rd_idx_r] ? meta_rd_r[MW-1:IW] : '0;
  assign eff_rank = mv_r[rd_idx_r] ? meta_rd_r[IW-1:0] : rd_idx_r;
  assign cnt_p1   = eff_cnt + CNT_ONE;
  assign cnt_m1   = eff_cnt - CNT_ONE;
  assign hit      = used_r[rd_idx_r] && (tag_rd_r == {dev_r, sector_r});
  assign take     = (eff_cnt == '0) && (!cand_found_r || (eff_rank < cand_rank_r));
  assign c_found  = cand_found_r || take;
  assign c_idx    = take ? rd_idx_r : cand_idx_r;
  assign c_rank   = take ? eff_rank : cand_rank_r;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= {dev_r, sector_r};
    end
    if (meta_we) begin
      meta_mem[wr_addr] <= meta_wdata;
    end
    tag_rd_r  <= tag_mem[rd_addr];
    meta_rd_r <= meta_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_vld_r     <= 1'b0;
      cand_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      used_r       <= '0;
      mv_r         <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      cand_found_r <= cand_found_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      if (set_used) begin
        used_r[wr_addr] <= 1'b1;
      end
      if (meta_we) begin
        mv_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    cand_idx_r   <= cand_idx_nxt;
    cand_rank_r  <= cand_rank_nxt;
    sweep_rank_r <= sweep_rank_nxt;
    out_entry_r  <= out_entry_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    if (accept) begin
      func_r   <= in_func;
      dev_r    <= in_dev;
      sector_r <= in_sector;
      slot_r   <= in_slot;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    rd_addr        = IW'(idx_r);
    wr_addr        = rd_idx_r;
    tag_we         = 1'b0;
    meta_we        = 1'b0;
    set_used       = 1'b0;
    meta_wdata     = {eff_cnt, eff_rank};
    cand_found_nxt = cand_found_r;
    cand_idx_nxt   = cand_idx_r;
    cand_rank_nxt  = cand_rank_r;
    sweep_rank_nxt = sweep_rank_r;
    out_valid_nxt  = 1'b0;
    out_entry_nxt  = out_entry_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt        = '0;
          cand_found_nxt = 1'b0;
          state_nxt      = (in_func == FUNC_GET) ? ST_SCAN : ST_SLOT_RD;
        end
      end

      ST_SCAN: begin
        if (idx_r < N_CNT) begin
          rd_addr    = IW'(idx_r);
          rd_idx_nxt = IW'(idx_r);
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (hit) begin
            wr_addr       = rd_idx_r;
            out_valid_nxt = 1'b1;
            out_entry_nxt = SLOT_W'(rd_idx_r);
            if (eff_cnt == CNT_MAX) begin
              out_status_nxt = STATUS_OVER;
              out_count_nxt  = CNT_MAX;
            end else begin
              meta_we        = 1'b1;
              meta_wdata     = {cnt_p1, eff_rank};
              out_status_nxt = STATUS_OK;
              out_count_nxt  = cnt_p1;
            end
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end else begin
            cand_found_nxt = c_found;
            cand_idx_nxt   = c_idx;
            cand_rank_nxt  = c_rank;
            if (rd_idx_r == LAST_IDX) begin
              out_valid_nxt = 1'b1;
              if (c_found) begin
                wr_addr        = c_idx;
                tag_we         = 1'b1;
                meta_we        = 1'b1;
                set_used       = 1'b1;
                meta_wdata     = {CNT_ONE, c_rank};
                out_entry_nxt  = SLOT_W'(c_idx);
                out_status_nxt = STATUS_MISS;
                out_count_nxt  = CNT_ONE;
              end else begin
                out_entry_nxt  = '0;
                out_status_nxt = STATUS_NOFREE;
                out_count_nxt  = '0;
              end
              rd_vld_nxt = 1'b0;
              state_nxt  = ST_IDLE;
            end
          end
        end
      end

      ST_SLOT_RD: begin
        if (int'(slot_r) >= NUM_BUFFERS) begin
          out_valid_nxt  = 1'b1;
          out_entry_nxt  = slot_r;
          out_status_nxt = STATUS_UNDER;
          out_count_nxt  = '0;
          state_nxt      = ST_IDLE;
        end else begin
          rd_addr    = slot_idx;
          rd_idx_nxt = slot_idx;
          rd_vld_nxt = 1'b1;
          state_nxt  = ST_SLOT_UPD;
        end
      end

      ST_SLOT_UPD: begin
        wr_addr       = rd_idx_r;
        out_entry_nxt = slot_r;
        state_nxt     = ST_IDLE;
        if (func_r == FUNC_PIN) begin
          out_valid_nxt = 1'b1;
          if (eff_cnt == CNT_MAX) begin
            out_status_nxt = STATUS_OVER;
            out_count_nxt  = CNT_MAX;
          end else begin
            meta_we        = 1'b1;
            meta_wdata     = {cnt_p1, eff_rank};
            out_status_nxt = STATUS_OK;
            out_count_nxt  = cnt_p1;
          end
        end else if (eff_cnt == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_UNDER;
          out_count_nxt  = '0;
        end else if ((func_r == FUNC_RELEASE) && (cnt_m1 == '0)) begin
          sweep_rank_nxt = eff_rank;
          idx_nxt        = '0;
          state_nxt      = ST_SWEEP;
        end else begin
          meta_we        = 1'b1;
          meta_wdata     = {cnt_m1, eff_rank};
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_count_nxt  = cnt_m1;
        end
      end

      ST_SWEEP: begin
        if (idx_r < N_CNT) begin
          rd_addr    = IW'(idx_r);
          rd_idx_nxt = IW'(idx_r);
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (eff_rank > sweep_rank_r) begin
            wr_addr    = rd_idx_r;
            meta_we    = 1'b1;
            meta_wdata = {eff_cnt, eff_rank - 1'b1};
          end
          if (rd_idx_r == LAST_IDX) begin
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_FINAL;
          end
        end
      end

      ST_FINAL: begin
        wr_addr        = slot_idx;
        meta_we        = 1'b1;
        meta_wdata     = {{CNT_W{1'b0}}, LAST_IDX};
        out_valid_nxt  = 1'b1;
        out_entry_nxt  = slot_r;
        out_status_nxt = STATUS_OK;
        out_count_nxt  = '0;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_entry       = out_entry_r;
  assign out_status      = out_status_r;
  assign out_count_after = out_count_r;

endmodule

// File: rtl/core/lrubc_checker.sv
// ----------------------------------------------------------------------------
// LRU buffer cache port checker
// Watches the ports of the cache engine for item and result sequencing.
// ----------------------------------------------------------------------------
module lrubc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [lrubc_pkg::SLOT_W-1:0]   out_entry,
  input lrubc_pkg::status_t        out_status,
  input lrubc_pkg::cnt_t           out_count_after
);
  import lrubc_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted item");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_MISS)) |-> (out_count_after == CNT_ONE))
    else $error("claimed entry does not report a count of one");

  a_under_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_UNDER)) |-> (out_count_after == '0))
    else $error("underflow result reports a nonzero count");

  a_no_result_while_idle_item: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result shown in the cycle after an item was accepted");

endmodule

bind lru_block_buffer_cache_unit lrubc_checker u_lrubc_checker (.*);
